### design/pcsa_pkg.sv
// Shared types, constants and codes for the particle cell scatter-add block.
package pcsa_pkg;

   // Field widths fixed by the item format.
   localparam int CELL_IDX_W = 12;
   localparam int VALUE_W    = 32;
   localparam int WEIGHT_W   = 17;
   localparam int SUM_W      = 48;
   localparam int PROD_W     = 50;
   localparam int CONTRIB_W  = 33;

   // Weight of exactly one in Q1.16.
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

   // Saturation limits of the Q32.16 accumulators.
   localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN = 48'sh8000_0000_0000;

   // Defaults for the top-level parameters.
   localparam int DEF_NUM_CELLS   = 4096;
   localparam int DEF_QUEUE_DEPTH = 4;

   // Operation codes.
   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_SUB   = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } back_state_type;

   // One classified operation, handed from the front end to the back end.
   typedef struct packed {
      op_type                       op;
      logic [CELL_IDX_W-1:0]        cell_addr;
      logic signed [CONTRIB_W-1:0]  dx;
      logic signed [CONTRIB_W-1:0]  dy;
      logic signed [CONTRIB_W-1:0]  dz;
   } q_entry_type;

endpackage

### design/pcsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/pcsa_front.sv
// Front end: accepts items, drops out-of-mesh ones and forms the rounded contributions.
module pcsa_front #(
   parameter int NUM_CELLS = pcsa_pkg::DEF_NUM_CELLS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     hold,
   input  logic                                     req_push,
   output logic                                     req_full,
   input  logic [1:0]                               req_opcode,
   input  logic signed [12:0]                       req_cell_index,
   input  logic signed [pcsa_pkg::VALUE_W-1:0]      req_value_x,
   input  logic signed [pcsa_pkg::VALUE_W-1:0]      req_value_y,
   input  logic signed [pcsa_pkg::VALUE_W-1:0]      req_value_z,
   input  logic [pcsa_pkg::WEIGHT_W-1:0]            req_weight,
   output logic                                     q_push,
   output pcsa_pkg::q_entry_type                    q_data,
   input  logic                                     q_full
);
   import pcsa_pkg::*;

   logic                  accept;
   logic                  in_range;
   logic                  ready1;
   logic                  ready2;
   logic [WEIGHT_W-1:0]   w_sat;
   logic [PROD_W-1:0]     prod_x;
   logic [PROD_W-1:0]     prod_y;
   logic [PROD_W-1:0]     prod_z;
   logic [PROD_W-1:0]     rnd_x;
   logic [PROD_W-1:0]     rnd_y;
   logic [PROD_W-1:0]     rnd_z;

   logic                  s1_valid_ff, s1_valid_in;
   op_type                s1_op_ff;
   logic [CELL_IDX_W-1:0] s1_cell_ff;
   logic [PROD_W-1:0]     s1_prod_x_ff;
   logic [PROD_W-1:0]     s1_prod_y_ff;
   logic [PROD_W-1:0]     s1_prod_z_ff;

   logic                  s2_valid_ff, s2_valid_in;
   q_entry_type           s2_entry_ff, s2_entry_in;

   // Stage handshake: each stage moves when the one after it has room.
   assign ready2   = !s2_valid_ff || !q_full;
   assign ready1   = !s1_valid_ff || ready2;
   assign req_full = hold || !ready1;
   assign accept   = req_push && !req_full;

   // Classification: a negative index or one beyond the store is dropped here.
   assign in_range = !req_cell_index[12] && (32'(req_cell_index[11:0]) < NUM_CELLS);

   // Weight saturates at one, then value times weight for each component.
   assign w_sat  = (req_weight > WEIGHT_ONE) ? WEIGHT_ONE : req_weight;
   assign prod_x = {{(PROD_W-VALUE_W){req_value_x[VALUE_W-1]}}, req_value_x} *
                   {{(PROD_W-WEIGHT_W){1'b0}}, w_sat};
   assign prod_y = {{(PROD_W-VALUE_W){req_value_y[VALUE_W-1]}}, req_value_y} *
                   {{(PROD_W-WEIGHT_W){1'b0}}, w_sat};
   assign prod_z = {{(PROD_W-VALUE_W){req_value_z[VALUE_W-1]}}, req_value_z} *
                   {{(PROD_W-WEIGHT_W){1'b0}}, w_sat};

   // Round to nearest, ties up, then drop the 16 fraction bits.
   assign rnd_x = s1_prod_x_ff + PROD_W'(32768);
   assign rnd_y = s1_prod_y_ff + PROD_W'(32768);
   assign rnd_z = s1_prod_z_ff + PROD_W'(32768);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (ready1) begin
         s1_valid_in = accept && in_range;
      end
      s2_valid_in = s2_valid_ff;
      if (ready2) begin
         s2_valid_in = s1_valid_ff;
      end
      s2_entry_in.op        = s1_op_ff;
      s2_entry_in.cell_addr = s1_cell_ff;
      s2_entry_in.dx        = rnd_x[48:16];
      s2_entry_in.dy        = rnd_y[48:16];
      s2_entry_in.dz        = rnd_z[48:16];
   end

   // Valid bits of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Stage payloads load on a transfer into the stage.
   always_ff @(posedge clock) begin
      if (ready1 && accept) begin
         s1_op_ff     <= op_type'(req_opcode);
         s1_cell_ff   <= req_cell_index[11:0];
         s1_prod_x_ff <= prod_x;
         s1_prod_y_ff <= prod_y;
         s1_prod_z_ff <= prod_z;
      end
      if (ready2 && s1_valid_ff) begin
         s2_entry_ff <= s2_entry_in;
      end
   end

   assign q_push = s2_valid_ff && !q_full;
   assign q_data = s2_entry_ff;

endmodule

### design/pcsa_queue.sv
// Short queue of classified operations between the front end and the back end.
module pcsa_queue #(
   parameter int DEPTH = pcsa_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pcsa_pkg::q_entry_type push_data,
   output logic                  full,
   input  logic                  pop,
   output pcsa_pkg::q_entry_type pop_data,
   output logic                  empty
);
   import pcsa_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   q_entry_type       entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer wrap and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/pcsa_back.sv
// Back end: clears the cell store after reset and runs read-modify-write per add, sub or clear, a read per read.
module pcsa_back #(
   parameter int NUM_CELLS = pcsa_pkg::DEF_NUM_CELLS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_empty,
   output logic                                  q_pop,
   input  pcsa_pkg::q_entry_type                 q_data,
   output logic                                  clearing,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [pcsa_pkg::CELL_IDX_W-1:0]       rsp_read_cell,
   output logic signed [pcsa_pkg::SUM_W-1:0]     rsp_sum_x,
   output logic signed [pcsa_pkg::SUM_W-1:0]     rsp_sum_y,
   output logic signed [pcsa_pkg::SUM_W-1:0]     rsp_sum_z
);
   import pcsa_pkg::*;

   localparam int AW    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int RAM_W = 3 * SUM_W;

   back_state_type         state_ff, state_in;
   logic [AW-1:0]          clr_addr_ff, clr_addr_in;
   q_entry_type            item_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [CELL_IDX_W-1:0]  out_cell_ff;
   logic signed [SUM_W-1:0] out_x_ff;
   logic signed [SUM_W-1:0] out_y_ff;
   logic signed [SUM_W-1:0] out_z_ff;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [RAM_W-1:0]       ram_wr_data;
   logic                   ram_rd_en;
   logic [RAM_W-1:0]       ram_rd_data;
   logic                   out_free;
   logic                   out_load;
   logic signed [SUM_W-1:0] acc_x;
   logic signed [SUM_W-1:0] acc_y;
   logic signed [SUM_W-1:0] acc_z;
   logic signed [SUM_W-1:0] new_x;
   logic signed [SUM_W-1:0] new_y;
   logic signed [SUM_W-1:0] new_z;
   logic                   is_sub;

   // Saturating add or subtract of a contribution to a 48-bit accumulator.
   function automatic logic signed [SUM_W-1:0] sat_acc(
      input logic signed [SUM_W-1:0]     acc,
      input logic signed [CONTRIB_W-1:0] d,
      input logic                        sub
   );
      logic signed [SUM_W:0] a;
      logic signed [SUM_W:0] b;
      logic signed [SUM_W:0] s;
      a = {acc[SUM_W-1], acc};
      b = {{(SUM_W+1-CONTRIB_W){d[CONTRIB_W-1]}}, d};
      s = sub ? (a - b) : (a + b);
      if (s[SUM_W] != s[SUM_W-1]) begin
         return s[SUM_W] ? SUM_MIN : SUM_MAX;
      end
      return s[SUM_W-1:0];
   endfunction

   pcsa_ram #(
      .WIDTH (RAM_W),
      .DEPTH (NUM_CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (AW'(q_data.cell_addr)),
      .rd_data (ram_rd_data)
   );

   // Accumulator update from the stored sums.
   assign acc_x  = ram_rd_data[SUM_W-1:0];
   assign acc_y  = ram_rd_data[2*SUM_W-1:SUM_W];
   assign acc_z  = ram_rd_data[3*SUM_W-1:2*SUM_W];
   assign is_sub = (item_ff.op == OP_SUB);
   assign new_x  = sat_acc(acc_x, item_ff.dx, is_sub);
   assign new_y  = sat_acc(acc_y, item_ff.dy, is_sub);
   assign new_z  = sat_acc(acc_z, item_ff.dz, is_sub);

   assign out_free = !out_valid_ff || rsp_pop;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == AW'(NUM_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (item_ff.op != OP_READ || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = AW'(item_ff.cell_addr);
      ram_wr_data = {new_z, new_y, new_x};
      ram_rd_en   = 1'b0;
      q_pop       = 1'b0;
      out_load    = 1'b0;
      clearing    = 1'b0;
      clr_addr_in = clr_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clearing    = 1'b1;
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            q_pop     = !q_empty;
            ram_rd_en = !q_empty;
         end
         ST_UPDATE: begin
            case (item_ff.op)
               OP_ADD, OP_SUB: begin
                  ram_wr_en = 1'b1;
               end
               OP_CLEAR: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = '0;
               end
               OP_READ: begin
                  out_load = out_free;
               end
               default: begin
                  ram_wr_en = 1'b0;
               end
            endcase
         end
         default: begin
            clearing = 1'b1;
         end
      endcase
   end

   // Result register: a waiting result leaves on a transfer.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_data;
      end
      if (out_load) begin
         out_cell_ff <= item_ff.cell_addr;
         out_x_ff    <= acc_x;
         out_y_ff    <= acc_y;
         out_z_ff    <= acc_z;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_read_cell = out_cell_ff;
   assign rsp_sum_x     = out_x_ff;
   assign rsp_sum_y     = out_y_ff;
   assign rsp_sum_z     = out_z_ff;

endmodule

### design/particle_cell_scatter_add.sv
// Particle-to-mesh scatter-add with per-cell saturating accumulators (top level).
// A read result passes front-end stages s1 and s2, the queue, the item register and the
// result register; the back end finishes one item's cell RAM access before it takes the next.
// Reset is synchronous; afterwards a clearing pass zeroes every cell of the store,
// and req_full stays high during it.
module particle_cell_scatter_add #(
   parameter int NUM_CELLS   = pcsa_pkg::DEF_NUM_CELLS,
   parameter int QUEUE_DEPTH = pcsa_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [1:0]                           req_opcode,
   input  logic signed [12:0]                   req_cell_index,
   input  logic signed [pcsa_pkg::VALUE_W-1:0]  req_value_x,
   input  logic signed [pcsa_pkg::VALUE_W-1:0]  req_value_y,
   input  logic signed [pcsa_pkg::VALUE_W-1:0]  req_value_z,
   input  logic [pcsa_pkg::WEIGHT_W-1:0]        req_weight,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [pcsa_pkg::CELL_IDX_W-1:0]      rsp_read_cell,
   output logic signed [pcsa_pkg::SUM_W-1:0]    rsp_sum_x,
   output logic signed [pcsa_pkg::SUM_W-1:0]    rsp_sum_y,
   output logic signed [pcsa_pkg::SUM_W-1:0]    rsp_sum_z
);
   import pcsa_pkg::*;

   logic        clearing;
   logic        q_push;
   logic        q_full;
   logic        q_pop;
   logic        q_empty;
   q_entry_type q_push_data;
   q_entry_type q_pop_data;

   pcsa_front #(
      .NUM_CELLS (NUM_CELLS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .hold           (clearing),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_opcode     (req_opcode),
      .req_cell_index (req_cell_index),
      .req_value_x    (req_value_x),
      .req_value_y    (req_value_y),
      .req_value_z    (req_value_z),
      .req_weight     (req_weight),
      .q_push         (q_push),
      .q_data         (q_push_data),
      .q_full         (q_full)
   );

   pcsa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   pcsa_back #(
      .NUM_CELLS (NUM_CELLS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .q_data        (q_pop_data),
      .clearing      (clearing),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_read_cell (rsp_read_cell),
      .rsp_sum_x     (rsp_sum_x),
      .rsp_sum_y     (rsp_sum_y),
      .rsp_sum_z     (rsp_sum_z)
   );

endmodule

### design/pcsa_checker.sv
// Port-level checks for the scatter-add block, bound to the top level.
module pcsa_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_full,
   input logic                                 rsp_empty,
   input logic                                 rsp_pop,
   input logic [pcsa_pkg::CELL_IDX_W-1:0]      rsp_read_cell,
   input logic signed [pcsa_pkg::SUM_W-1:0]    rsp_sum_x,
   input logic signed [pcsa_pkg::SUM_W-1:0]    rsp_sum_y,
   input logic signed [pcsa_pkg::SUM_W-1:0]    rsp_sum_z
);

   // Reset empties the result side and starts the clearing pass, which blocks input.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (req_full && rsp_empty))
      else $error("block not full and empty after reset");

   // A result cannot appear right after reset: the clearing pass and the pipe come first.
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_empty) |-> (!$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3)))
      else $error("result appeared too soon after reset");

   // A result waiting without a transfer stays, with the same payload.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_read_cell) &&
         $stable(rsp_sum_x) && $stable(rsp_sum_y) && $stable(rsp_sum_z)))
      else $error("waiting result changed or vanished");

   // No result without input: with no transfer in, a drained result side stays drained.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (req_full && rsp_empty && $past(req_full) && $past(req_full, 2) &&
       $past(req_full, 3) && $past(req_full, 4) && $past(rsp_empty)) |=> rsp_empty ||
       !$past(req_full, 4))
      else $error("result appeared without a transfer in");

endmodule

bind particle_cell_scatter_add pcsa_checker u_pcsa_checker (.*);
